/* hdl/tsfa_pkg.sv */
`default_nettype none

package tsfa_pkg;

    // Filter and converter sizes.
    localparam int TAPS     = 12;
    localparam int ADC_BITS = 10;
    localparam int IDX_W    = (TAPS > 1) ? $clog2(TAPS) : 1;

    // Register widths and reset values.
    localparam int AMB_W    = 8;
    localparam int SCALE_W  = 18;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [AMB_W-1:0]    AMB_RESET    = AMB_W'(25);
    localparam logic [SCALE_W-1:0]  SCALE0_RESET = SCALE_W'(55627);
    localparam logic [SCALE_W-1:0]  SCALE1_RESET = SCALE_W'(56063);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(5461);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE0  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE1  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT  = 2'd3;

    // Scaling datapath: code times scale, Q16 down to Q8, plus ambient in Q8.
    localparam int SCALE_SHIFT = 8;
    localparam int PROD_W      = ADC_BITS + SCALE_W;
    localparam int AMB_Q8_W    = AMB_W + SCALE_SHIFT;
    localparam int SHIFTED_W   = PROD_W - SCALE_SHIFT;
    localparam int SC_SUM_W    = ((SHIFTED_W > AMB_Q8_W) ? SHIFTED_W : AMB_Q8_W) + 1;
    localparam int SCALED_W    = 19;
    localparam logic [SCALED_W-1:0] SCALED_MAX = {SCALED_W{1'b1}};

    // Filter datapath: ring sum times weight, Q24 down to whole degrees.
    localparam int SUM_W       = SCALED_W + IDX_W;
    localparam int FPROD_W     = SUM_W + WEIGHT_W;
    localparam int OUT_SHIFT   = 24;
    localparam int DEG_W       = FPROD_W - OUT_SHIFT;
    localparam int OUT_W       = 11;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Ring memory holds both channels, one half each.
    localparam int MEM_AW    = IDX_W + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // Queue between the scaler and the filter; the depth is a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One scaled sample waiting for the filter.
    typedef struct packed {
        logic                ch;
        logic [SCALED_W-1:0] value;
    } sample_t;

    // Scaler sequencer.
    typedef enum logic [0:0] {
        F_IDLE,
        F_SCALE
    } front_state_t;

    // Filter sequencer.
    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_DRAIN,
        B_MUL,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

/* hdl/thermocouple_scale_fir_average.sv */
`default_nettype none

// Channel      | Direction | Payload
// s_*          | in        | tuser: channel; tdata: adc_code (zero padded to 16 bits)
// m_*          | out       | tuser: channel_out; tdata: filtered_temp (zero padded)
// cfg_*        | in        | cfg_index selects the register, cfg_data low bits are kept
//
// An accepted item is scaled, queued, summed over every tap, weighted and registered
// at the output. The filter reads one ring entry per cycle from the ring memory,
// which sets the sustained item rate; the scaler takes the next item while the
// filter runs.
// Reset clears the rings (by per-entry written flags) and ring positions, and loads the register reset values.
// A stalled output holds its result; the filter waits on it, then the queue fills.

module thermocouple_scale_fir_average (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,   // [9:0] adc_code
    input  wire logic [0:0]                        s_tuser,   // [0] channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata,   // [10:0] filtered_temp
    output logic [0:0]                             m_tuser,   // [0] channel_out
    input  wire logic                              cfg_we,
    input  wire logic [tsfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tsfa_pkg::CFG_W-1:0]        cfg_data
);

    logic [tsfa_pkg::AMB_W-1:0]    ambient_reg;
    logic [tsfa_pkg::SCALE_W-1:0]  scale0_reg;
    logic [tsfa_pkg::SCALE_W-1:0]  scale1_reg;
    logic [tsfa_pkg::WEIGHT_W-1:0] weight_reg;

    logic                          q_push, q_full, q_pop, q_empty;
    tsfa_pkg::sample_t             q_in_item, q_out_item;
    logic [tsfa_pkg::OUT_W-1:0]    out_temp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg <= tsfa_pkg::AMB_RESET;
            scale0_reg  <= tsfa_pkg::SCALE0_RESET;
            scale1_reg  <= tsfa_pkg::SCALE1_RESET;
            weight_reg  <= tsfa_pkg::WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsfa_pkg::REG_AMBIENT: ambient_reg <= cfg_data[tsfa_pkg::AMB_W-1:0];
                tsfa_pkg::REG_SCALE0:  scale0_reg  <= cfg_data[tsfa_pkg::SCALE_W-1:0];
                tsfa_pkg::REG_SCALE1:  scale1_reg  <= cfg_data[tsfa_pkg::SCALE_W-1:0];
                tsfa_pkg::REG_WEIGHT:  weight_reg  <= cfg_data[tsfa_pkg::WEIGHT_W-1:0];
                default:               ambient_reg <= ambient_reg;
            endcase
        end
    end

    // Scaler: accepts items and turns codes into degrees.
    tsfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ch     (s_tuser[0]),
        .in_code   (s_tdata[tsfa_pkg::ADC_BITS-1:0]),
        .ambient   (ambient_reg),
        .scale0    (scale0_reg),
        .scale1    (scale1_reg),
        .push      (q_push),
        .push_item (q_in_item),
        .q_full    (q_full)
    );

    // Queue of scaled samples.
    tsfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    // Filter: ring update, tap sum and weighting.
    tsfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_out_item),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .weight    (weight_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ch    (m_tuser[0]),
        .out_temp  (out_temp)
    );

    assign m_tdata = {{(16 - tsfa_pkg::OUT_W){1'b0}}, out_temp};

    // The scaler never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("push into full queue");

    // The filter never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // An accepted item keeps the scaler busy for the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("scaler ready right after accepting an item");

    // A pop starts a tap sweep, so no second pop follows at once.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> !q_pop)
        else $error("back to back pops");

endmodule

`default_nettype wire

/* hdl/tsfa_front.sv */
`default_nettype none

module tsfa_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             in_ch,
    input  wire logic [tsfa_pkg::ADC_BITS-1:0]    in_code,
    input  wire logic [tsfa_pkg::AMB_W-1:0]       ambient,
    input  wire logic [tsfa_pkg::SCALE_W-1:0]     scale0,
    input  wire logic [tsfa_pkg::SCALE_W-1:0]     scale1,
    output logic                                  push,
    output tsfa_pkg::sample_t                     push_item,
    input  wire logic                             q_full
);

    tsfa_pkg::front_state_t state_reg, state_next;

    logic                             ch_reg;
    logic [tsfa_pkg::PROD_W-1:0]      prod_reg;
    logic [tsfa_pkg::SCALE_W-1:0]     scale_sel;
    logic [tsfa_pkg::SC_SUM_W-1:0]    sc_sum;
    logic                             accept;

    assign accept    = in_valid && in_ready;
    assign scale_sel = in_ch ? scale1 : scale0;

    // Next state: multiply into a register, then wait for room in the queue.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsfa_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tsfa_pkg::F_SCALE;
                end
            end
            tsfa_pkg::F_SCALE:
            begin
                if (!q_full)
                begin
                    state_next = tsfa_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = tsfa_pkg::F_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            tsfa_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
            end
            tsfa_pkg::F_SCALE:
            begin
                push = !q_full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsfa_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Product of code and the channel's degrees per count, in Q16.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= in_ch;
            prod_reg <= tsfa_pkg::PROD_W'(in_code) * tsfa_pkg::PROD_W'(scale_sel);
        end
    end

    // Drop to Q8, add the cold junction temperature and saturate.
    always_comb
    begin
        sc_sum = tsfa_pkg::SC_SUM_W'(prod_reg[tsfa_pkg::PROD_W-1:tsfa_pkg::SCALE_SHIFT])
               + tsfa_pkg::SC_SUM_W'({ambient, {tsfa_pkg::SCALE_SHIFT{1'b0}}});
        push_item.ch = ch_reg;
        if (sc_sum > tsfa_pkg::SC_SUM_W'(tsfa_pkg::SCALED_MAX))
        begin
            push_item.value = tsfa_pkg::SCALED_MAX;
        end
        else
        begin
            push_item.value = sc_sum[tsfa_pkg::SCALED_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* hdl/tsfa_queue.sv */
`default_nettype none

module tsfa_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tsfa_pkg::sample_t   push_item,
    output logic                     full,
    input  wire logic                pop,
    output tsfa_pkg::sample_t        pop_item,
    output logic                     empty
);

    tsfa_pkg::sample_t                 entry_reg [tsfa_pkg::Q_DEPTH];
    logic [tsfa_pkg::Q_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [tsfa_pkg::Q_CNT_W-1:0]      cnt_reg;

    assign full     = (cnt_reg == tsfa_pkg::Q_CNT_W'(tsfa_pkg::Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/tsfa_back.sv */
`default_nettype none

module tsfa_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tsfa_pkg::sample_t                q_item,
    input  wire logic                             q_empty,
    output logic                                  pop,
    input  wire logic [tsfa_pkg::WEIGHT_W-1:0]    weight,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  out_ch,
    output logic [tsfa_pkg::OUT_W-1:0]            out_temp
);

    tsfa_pkg::back_state_t state_reg, state_next;

    logic [tsfa_pkg::SCALED_W-1:0]  ring_mem [tsfa_pkg::MEM_DEPTH];
    logic [tsfa_pkg::MEM_DEPTH-1:0] written_reg;
    logic [tsfa_pkg::IDX_W-1:0]     wpos_reg [2];
    logic [tsfa_pkg::IDX_W-1:0]     wpos_next;

    logic                           ch_reg;
    logic [tsfa_pkg::IDX_W-1:0]     idx_reg;
    logic                           idx_last;
    logic [tsfa_pkg::MEM_AW-1:0]    wr_addr, rd_addr;
    logic [tsfa_pkg::SCALED_W-1:0]  rd_data_reg;
    logic                           rd_written_reg;
    logic                           acc_en_reg;
    logic [tsfa_pkg::SUM_W-1:0]     acc_reg;
    logic [tsfa_pkg::FPROD_W-1:0]   fprod_reg;
    logic [tsfa_pkg::DEG_W-1:0]     deg;
    logic                           load_out;
    logic                           out_valid_reg;

    assign idx_last = (idx_reg == tsfa_pkg::IDX_W'(tsfa_pkg::TAPS - 1));

    // Ring position advances before the write and wraps at the tap count.
    always_comb
    begin
        if (wpos_reg[q_item.ch] == tsfa_pkg::IDX_W'(tsfa_pkg::TAPS - 1))
        begin
            wpos_next = '0;
        end
        else
        begin
            wpos_next = wpos_reg[q_item.ch] + 1'b1;
        end
    end

    assign wr_addr = {q_item.ch, wpos_next};
    assign rd_addr = {ch_reg, idx_reg};

    // Next state: take a sample, read every tap, weight the sum, hand it over.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsfa_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = tsfa_pkg::B_SUM;
                end
            end
            tsfa_pkg::B_SUM:
            begin
                if (idx_last)
                begin
                    state_next = tsfa_pkg::B_DRAIN;
                end
            end
            tsfa_pkg::B_DRAIN:
            begin
                state_next = tsfa_pkg::B_MUL;
            end
            tsfa_pkg::B_MUL:
            begin
                state_next = tsfa_pkg::B_OUT;
            end
            tsfa_pkg::B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = tsfa_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = tsfa_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            tsfa_pkg::B_IDLE:
            begin
                pop = !q_empty;
            end
            tsfa_pkg::B_OUT:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsfa_pkg::B_IDLE;
            written_reg   <= '0;
            wpos_reg[0]   <= '0;
            wpos_reg[1]   <= '0;
            idx_reg       <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_en_reg <= (state_reg == tsfa_pkg::B_SUM);
            if (pop)
            begin
                written_reg[wr_addr]   <= 1'b1;
                wpos_reg[q_item.ch]    <= wpos_next;
                idx_reg                <= '0;
            end
            else if (state_reg == tsfa_pkg::B_SUM)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ring memory: the new sample is written on pop, taps are read one a cycle.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ring_mem[wr_addr] <= q_item.value;
        end
        rd_data_reg    <= ring_mem[rd_addr];
        rd_written_reg <= written_reg[rd_addr];
    end

    // Tap accumulation; an entry never written counts as zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ch_reg  <= q_item.ch;
            acc_reg <= '0;
        end
        else if (acc_en_reg && rd_written_reg)
        begin
            acc_reg <= acc_reg + tsfa_pkg::SUM_W'(rd_data_reg);
        end
        if (state_reg == tsfa_pkg::B_MUL)
        begin
            fprod_reg <= tsfa_pkg::FPROD_W'(acc_reg) * tsfa_pkg::FPROD_W'(weight);
        end
    end

    // Whole degrees, saturated to the output range.
    assign deg = fprod_reg[tsfa_pkg::FPROD_W-1:tsfa_pkg::OUT_SHIFT];

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch <= ch_reg;
            if (deg > tsfa_pkg::DEG_W'(tsfa_pkg::OUT_MAX))
            begin
                out_temp <= tsfa_pkg::OUT_MAX;
            end
            else
            begin
                out_temp <= deg[tsfa_pkg::OUT_W-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* tb/sv/thermocouple_filter_checker.sv */
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the thermocouple filter.
// Every accepted sample is run through a cycle-free model of the scaler and the
// per-channel moving average, and each result is compared with the oldest reading
// still owed by the block.
module thermocouple_filter_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [15:0]                    s_tdata,   // [9:0] adc_code
    input  wire logic [0:0]                     s_tuser,   // [0] channel
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [15:0]                    m_tdata,   // [10:0] filtered_temp
    input  wire logic [0:0]                     m_tuser,   // [0] channel_out
    input  wire logic                           cfg_we,
    input  wire logic [tsfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsfa_pkg::CFG_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  outstanding
);

    // One filtered reading as the block should deliver it.
    typedef struct packed {
        logic                       ch;
        logic [tsfa_pkg::OUT_W-1:0] temp;
    } reading_t;

    // Register copies, as last written on the configuration port.
    logic [tsfa_pkg::AMB_W-1:0]    ambient;
    logic [tsfa_pkg::SCALE_W-1:0]  scale_zero;
    logic [tsfa_pkg::SCALE_W-1:0]  scale_one;
    logic [tsfa_pkg::WEIGHT_W-1:0] weight;

    // Sample rings, one per channel, and the last written position of each.
    logic [tsfa_pkg::SCALED_W-1:0] ring_samples [2][tsfa_pkg::TAPS];
    int                            ring_head [2];

    reading_t pending_readings [$];
    reading_t want;
    int       errors;

    // Scale one code, store it in its channel's ring and return the filtered reading.
    function automatic logic [tsfa_pkg::OUT_W-1:0] filter_sample(
        input logic ch, input logic [tsfa_pkg::ADC_BITS-1:0] code);
        logic [31:0] scaled;
        logic [63:0] ring_sum;
        logic [63:0] degrees;
        int          i;
        scaled = ((32'(code) * 32'(ch ? scale_one : scale_zero)) >> 8) + (32'(ambient) << 8);
        if (scaled > 32'(tsfa_pkg::SCALED_MAX))
            scaled = 32'(tsfa_pkg::SCALED_MAX);
        ring_head[ch] = (ring_head[ch] + 1) % tsfa_pkg::TAPS;
        ring_samples[ch][ring_head[ch]] = scaled[tsfa_pkg::SCALED_W-1:0];
        ring_sum = '0;
        for (i = 0; i < tsfa_pkg::TAPS; i++)
            ring_sum += 64'(ring_samples[ch][i]);
        degrees = (ring_sum * 64'(weight)) >> 24;
        if (degrees > 64'(tsfa_pkg::OUT_MAX))
            degrees = 64'(tsfa_pkg::OUT_MAX);
        return degrees[tsfa_pkg::OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient    = tsfa_pkg::AMB_RESET;
            scale_zero = tsfa_pkg::SCALE0_RESET;
            scale_one  = tsfa_pkg::SCALE1_RESET;
            weight     = tsfa_pkg::WEIGHT_RESET;
            for (int c = 0; c < 2; c++)
            begin
                ring_head[c] = 0;
                for (int t = 0; t < tsfa_pkg::TAPS; t++)
                    ring_samples[c][t] = '0;
            end
            pending_readings.delete();
            errors = 0;
        end
        else
        begin
            // Register writes; only the low bits of each register are kept.
            if (cfg_we)
            begin
                case (cfg_index)
                    tsfa_pkg::REG_AMBIENT: ambient    = cfg_data[tsfa_pkg::AMB_W-1:0];
                    tsfa_pkg::REG_SCALE0:  scale_zero = cfg_data[tsfa_pkg::SCALE_W-1:0];
                    tsfa_pkg::REG_SCALE1:  scale_one  = cfg_data[tsfa_pkg::SCALE_W-1:0];
                    tsfa_pkg::REG_WEIGHT:  weight     = cfg_data[tsfa_pkg::WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // Each accepted sample owes exactly one reading.
            if (s_tvalid && s_tready)
            begin
                want.ch   = s_tuser[0];
                want.temp = filter_sample(s_tuser[0], s_tdata[tsfa_pkg::ADC_BITS-1:0]);
                pending_readings.push_back(want);
            end

            // Compare each delivered reading with the oldest one owed.
            if (m_tvalid && m_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reading: expected none, got ch %0d temp %0d",
                             $time, m_tuser[0], m_tdata[tsfa_pkg::OUT_W-1:0]);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (m_tuser[0] !== want.ch || m_tdata[tsfa_pkg::OUT_W-1:0] !== want.temp)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected ch %0d temp %0d, got ch %0d temp %0d",
                                 $time, want.ch, want.temp, m_tuser[0],
                                 m_tdata[tsfa_pkg::OUT_W-1:0]);
                    end
                end
            end
        end
        fail_count  <= errors;
        outstanding <= pending_readings.size();
    end

endmodule

/* tb/sv/tb_thermocouple_scale_fir_average.sv */
`timescale 1ns / 100ps

// Drives thermocouple samples and register settings into the filter, pulls the
// readings out with random back-pressure, and reports the verdict.
module tb_thermocouple_scale_fir_average;

    localparam int PHASES          = 7;
    localparam int PHASE_ITEMS     = 240;
    localparam int MODE_RUN        = 40;
    localparam int IDLE_MAX        = 12;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam logic [tsfa_pkg::CFG_W-1:0] CFG_ALL_ONES = '1;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;   // [9:0] adc_code
    logic [0:0]                     s_tuser;   // [0] channel
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;   // [10:0] filtered_temp
    logic [0:0]                     m_tuser;   // [0] channel_out
    logic                           cfg_we;
    logic [tsfa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tsfa_pkg::CFG_W-1:0]     cfg_data;

    int fail_count;
    int outstanding;
    int gap_max;
    int stall_max;
    int idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    thermocouple_scale_fir_average DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    thermocouple_filter_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one sample after a random gap and hold it until the block takes it.
    task automatic send_sample(input logic ch, input logic [tsfa_pkg::ADC_BITS-1:0] code);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(code);
        s_tuser  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering samples until every reading owed has been delivered.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles; the block is idle here.
    task automatic program_regs(input logic [tsfa_pkg::CFG_W-1:0] amb,
                                input logic [tsfa_pkg::CFG_W-1:0] s0,
                                input logic [tsfa_pkg::CFG_W-1:0] s1,
                                input logic [tsfa_pkg::CFG_W-1:0] wt);
        cfg_we    <= 1'b1;
        cfg_index <= tsfa_pkg::REG_AMBIENT;
        cfg_data  <= amb;
        @(posedge clk);
        cfg_index <= tsfa_pkg::REG_SCALE0;
        cfg_data  <= s0;
        @(posedge clk);
        cfg_index <= tsfa_pkg::REG_SCALE1;
        cfg_data  <= s1;
        @(posedge clk);
        cfg_index <= tsfa_pkg::REG_WEIGHT;
        cfg_data  <= wt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: a fresh random stall before each reading.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic                          ch;
        logic [tsfa_pkg::ADC_BITS-1:0] code;
        int                            mode;
        gap_max     = 0;
        stall_max   = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= tsfa_pkg::REG_AMBIENT;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: code extremes on both channels, alternating bits,
        // then enough full-scale samples to wrap the channel one ring.
        send_sample(1'b0, 10'd0);
        send_sample(1'b1, 10'd0);
        send_sample(1'b0, 10'd1023);
        send_sample(1'b1, 10'd1023);
        send_sample(1'b0, 10'h155);
        send_sample(1'b1, 10'h2AA);
        repeat (12) send_sample(1'b1, 10'd1023);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // All-ones writes: narrow registers keep their low bits, the scaled
        // value saturates and the filtered reading clips at full scale.
        program_regs(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
        repeat (6) send_sample(1'b0, 10'd1023);
        send_sample(1'b1, 10'd0);
        send_sample(1'b1, 10'd1);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Random phases, each under its own register setting.
        ch = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: program_regs(tsfa_pkg::CFG_W'(tsfa_pkg::AMB_RESET),
                                tsfa_pkg::CFG_W'(tsfa_pkg::SCALE0_RESET),
                                tsfa_pkg::CFG_W'(tsfa_pkg::SCALE1_RESET),
                                tsfa_pkg::CFG_W'(tsfa_pkg::WEIGHT_RESET));
                1: program_regs('0, '0, '0, '0);
                2: program_regs(18'd255, 18'h3FFFF, 18'h3FFFF, 18'hFFFF);
                3: program_regs(18'd0, 18'h3FFFF, 18'd1,
                                tsfa_pkg::CFG_W'(tsfa_pkg::WEIGHT_RESET));
                5: program_regs(18'h3FF00 | 18'd255, 18'd0, 18'h3FFFF, 18'h30000 | 18'hFFFF);
                default: program_regs(tsfa_pkg::CFG_W'($urandom_range(0, 18'h3FFFF)),
                                      tsfa_pkg::CFG_W'($urandom_range(0, 18'h3FFFF)),
                                      tsfa_pkg::CFG_W'($urandom_range(0, 18'h3FFFF)),
                                      tsfa_pkg::CFG_W'($urandom_range(0, 18'h3FFFF)));
            endcase

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Idling changes in runs, including runs with none at all.
                if (i % MODE_RUN == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    gap_max   = (mode[0]) ? IDLE_MAX : 0;
                    stall_max = (mode[1]) ? IDLE_MAX : 0;
                end
                if (i == PHASE_ITEMS / 2)
                    hold_until_drained();
                if ($urandom_range(0, 2) == 0)
                    ch = ~ch;
                case ($urandom_range(0, 9))
                    0:       code = 10'd0;
                    1:       code = 10'd1023;
                    default: code = tsfa_pkg::ADC_BITS'($urandom_range(0, 1023));
                endcase
                send_sample(ch, code);
            end
            hold_until_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
